// ===== src/assert_macros.svh =====
// assertion macros shared by the sorted list rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLI_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list assertion failed");

// next-cycle implication
`define SLI_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list assertion failed");

`endif

// ===== src/sli_pkg.sv =====
// types, codes and sizes for the sorted list insert/delete core
// no dependencies; used by the interfaces, the top level, the controller and the datapath
package sli_pkg;

  localparam int CAPACITY = 32;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [AW-1:0]             addr_t;
  typedef logic [CW-1:0]             count_t;
  typedef logic [POS_W-1:0]          pos_t;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SCAN,
    S_INS_PUT,
    S_DEL_SCAN,
    S_DUMP_START,
    S_DUMP_OUT,
    S_REPORT
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_TOP,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT_UP,
    WR_PUT_ABOVE,
    WR_PUT_ZERO,
    WR_SHIFT_DOWN
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    take;
    ptr_op_t ptr_op;
    logic    rd_en;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    logic    found_clr;
    logic    found_track;
    logic    status_set;
    status_t status_val;
    logic    out_load_entry;
    logic    out_load_report;
  } cmd_t;

  typedef struct packed {
    logic  req_valid;
    kind_t kind;
    logic  count_zero;
    logic  count_full;
    logic  ptr_at_zero;
    logic  ptr_at_last;
    logic  cmp_ge;
    logic  cmp_eq;
    logic  found;
    logic  out_free;
  } sts_t;

endpackage

// ===== src/sli_ifs.sv =====
// request and response channel interfaces of the sorted list core
// depends on sli_pkg
interface sli_req_if;
  import sli_pkg::*;
  logic   valid;
  logic   ready;
  kind_t  kind;
  value_t operand_value;
  modport source (output valid, output kind, output operand_value, input ready);
  modport sink   (input valid, input kind, input operand_value, output ready);
endinterface

interface sli_rsp_if;
  import sli_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  value_t  entry_value;
  pos_t    entry_position;
  logic    list_empty;
  logic    last_result;
  modport source (output valid, output status, output entry_value, output entry_position,
                  output list_empty, output last_result, input ready);
  modport sink   (input valid, input status, input entry_value, input entry_position,
                  input list_empty, input last_result, output ready);
endinterface

// ===== src/sorted_list_insert_delete_core.sv =====
// top level of the sorted list insert/delete core
// depends on sli_pkg, sli_ifs, sli_ctrl, sli_dp (and through it sli_ram)
//
//   channel  dir  payload                                             word
//   req      in   kind, operand_value                                 one operation
//   rsp      out  status, entry_value, entry_position, list_empty,    one listed entry
//                 last_result                                         or one status
//
// an operation on a list of n entries after it runs in order: accept, decode, a walk of
// the two-port table ram (insert walks down from the top shifting entries up, delete walks
// the whole list shifting entries down), a restart of the read, then the n words at one per
// cycle while rsp is not stalled; a full or empty rejection goes from decode straight to
// the status report, a delete of a missing value reports after walking the whole list
// synchronous reset empties the list at once, the table ram itself needs no clearing
// a stalled rsp holds the dump in place; req is taken again once the last word is queued
module sorted_list_insert_delete_core (
  input logic       clk,
  input logic       rst,
  sli_req_if.sink   req,
  sli_rsp_if.source rsp
);
  import sli_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // state machine: dispatch, table walk, dump of the list, status report
  sli_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // table memory, walk pointer, entry count and output word register
  sli_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

// ===== src/sli_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sli_ctrl.sv =====
// controller state machine of the sorted list core
// depends on sli_pkg and assert_macros.svh
`include "assert_macros.svh"

module sli_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  sli_pkg::sts_t sts,
  output sli_pkg::cmd_t cmd
);
  import sli_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next          = state;
    cmd                 = '0;
    cmd.ptr_op          = PTR_HOLD;
    cmd.wr_op           = WR_NONE;
    cmd.cnt_op          = CNT_HOLD;
    cmd.status_val      = ST_INSERTED;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.req_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.status_set = 1'b1;
        if (sts.kind == KIND_INSERT) begin
          if (sts.count_full) begin
            cmd.status_val = ST_FULL;
            state_next     = S_REPORT;
          end else if (sts.count_zero) begin
            cmd.status_val = ST_INSERTED;
            state_next     = S_INS_PUT;
          end else begin
            cmd.status_val = ST_INSERTED;
            cmd.ptr_op     = PTR_TOP;
            cmd.rd_en      = 1'b1;
            state_next     = S_INS_SCAN;
          end
        end else begin
          if (sts.count_zero) begin
            cmd.status_val = ST_EMPTY;
            state_next     = S_REPORT;
          end else begin
            cmd.status_val = ST_DELETED;
            cmd.ptr_op     = PTR_ZERO;
            cmd.rd_en      = 1'b1;
            cmd.found_clr  = 1'b1;
            state_next     = S_DEL_SCAN;
          end
        end
      end
      S_INS_SCAN: begin
        if (sts.cmp_ge) begin
          cmd.wr_op = WR_SHIFT_UP;
          if (sts.ptr_at_zero) begin
            state_next = S_INS_PUT;
          end else begin
            cmd.ptr_op = PTR_DEC;
            cmd.rd_en  = 1'b1;
          end
        end else begin
          cmd.wr_op  = WR_PUT_ABOVE;
          cmd.cnt_op = CNT_INC;
          state_next = S_DUMP_START;
        end
      end
      S_INS_PUT: begin
        cmd.wr_op  = WR_PUT_ZERO;
        cmd.cnt_op = CNT_INC;
        state_next = S_DUMP_START;
      end
      S_DEL_SCAN: begin
        cmd.found_track = 1'b1;
        if (sts.found) begin
          cmd.wr_op = WR_SHIFT_DOWN;
        end
        if (sts.ptr_at_last) begin
          if (sts.found || sts.cmp_eq) begin
            cmd.cnt_op = CNT_DEC;
            state_next = S_DUMP_START;
          end else begin
            cmd.status_set = 1'b1;
            cmd.status_val = ST_NOT_FOUND;
            state_next     = S_REPORT;
          end
        end else begin
          cmd.ptr_op = PTR_INC;
          cmd.rd_en  = 1'b1;
        end
      end
      S_DUMP_START: begin
        if (sts.count_zero) begin
          state_next = S_REPORT;
        end else begin
          cmd.ptr_op = PTR_ZERO;
          cmd.rd_en  = 1'b1;
          state_next = S_DUMP_OUT;
        end
      end
      S_DUMP_OUT: begin
        if (sts.out_free) begin
          cmd.out_load_entry = 1'b1;
          if (sts.ptr_at_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_op = PTR_INC;
            cmd.rd_en  = 1'b1;
          end
        end
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.out_load_report = 1'b1;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SLI_ASSERT_IMP(a_walk_needs_entries, clk, rst,
    state == S_INS_SCAN || state == S_DEL_SCAN || state == S_DUMP_OUT, !sts.count_zero)
  `SLI_ASSERT_IMP(a_load_only_when_free, clk, rst,
    cmd.out_load_entry || cmd.out_load_report, sts.out_free)

endmodule

// ===== src/sli_dp.sv =====
// datapath of the sorted list core: table ram, pointer, count, output word
// depends on sli_pkg, sli_ifs, sli_ram and assert_macros.svh
`include "assert_macros.svh"

module sli_dp (
  input  logic          clk,
  input  logic          rst,
  sli_req_if.sink       req,
  sli_rsp_if.source     rsp,
  input  sli_pkg::cmd_t cmd,
  output sli_pkg::sts_t sts
);
  import sli_pkg::*;

  kind_t   kind;
  value_t  operand;
  count_t  count;
  addr_t   ptr, ptr_next;
  logic    found;
  status_t status_reg;

  logic    we;
  addr_t   waddr;
  value_t  wdata;
  logic [VALUE_W-1:0] rdata_raw;
  value_t  rdata;

  logic    out_valid;
  status_t out_status;
  value_t  out_value;
  pos_t    out_pos;
  logic    out_empty;
  logic    out_last;

  assign req.ready = cmd.take;
  assign rdata     = value_t'(rdata_raw);

  // item latch
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind    <= req.kind;
      operand <= req.operand_value;
    end
  end

  // walk pointer; its next value is the read address
  always_comb begin
    case (cmd.ptr_op)
      PTR_TOP:  ptr_next = AW'(count - 1'b1);
      PTR_ZERO: ptr_next = '0;
      PTR_INC:  ptr_next = ptr + 1'b1;
      PTR_DEC:  ptr_next = ptr - 1'b1;
      default:  ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.status_set) begin
      status_reg <= cmd.status_val;
    end
    if (cmd.found_clr) begin
      found <= 1'b0;
    end else if (cmd.found_track) begin
      found <= found | sts.cmp_eq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + 1'b1;
        CNT_DEC: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // table writes
  always_comb begin
    we    = (cmd.wr_op != WR_NONE);
    waddr = '0;
    wdata = operand;
    case (cmd.wr_op)
      WR_SHIFT_UP: begin
        waddr = ptr + 1'b1;
        wdata = rdata;
      end
      WR_PUT_ABOVE: begin
        waddr = ptr + 1'b1;
      end
      WR_SHIFT_DOWN: begin
        waddr = ptr - 1'b1;
        wdata = rdata;
      end
      default: begin
        waddr = '0;
      end
    endcase
  end

  sli_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (ptr_next),
    .rdata (rdata_raw)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load_entry || cmd.out_load_report) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_entry) begin
      out_status <= status_reg;
      out_value  <= rdata;
      out_pos    <= POS_W'(ptr);
      out_empty  <= 1'b0;
      out_last   <= sts.ptr_at_last;
    end else if (cmd.out_load_report) begin
      out_status <= status_reg;
      out_value  <= '0;
      out_pos    <= '0;
      out_empty  <= sts.count_zero;
      out_last   <= 1'b1;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.entry_value    = out_value;
  assign rsp.entry_position = out_pos;
  assign rsp.list_empty     = out_empty;
  assign rsp.last_result    = out_last;

  // status toward the controller
  assign sts.req_valid   = req.valid;
  assign sts.kind        = kind;
  assign sts.count_zero  = (count == '0);
  assign sts.count_full  = (count == CW'(CAPACITY));
  assign sts.ptr_at_zero = (ptr == '0);
  assign sts.ptr_at_last = ((CW'(ptr) + 1'b1) == count);
  assign sts.cmp_ge      = (rdata >= operand);
  assign sts.cmp_eq      = (rdata == operand);
  assign sts.found       = found;
  assign sts.out_free    = !out_valid || rsp.ready;

  `SLI_ASSERT_IMP(a_write_within_list, clk, rst, we, CW'(waddr) <= count)
  `SLI_ASSERT_NEXT(a_count_no_wrap, clk, rst, cmd.cnt_op == CNT_INC, count != '0)

endmodule
